@@ rtl/core/tpcr_pkg.sv @@
// ============================================================================
// tpcr_pkg
// Shared types and constants of the touch point calibrate and rotate block.
// ============================================================================
package tpcr_pkg;

   localparam int RAW_BITS_DEF    = 12;
   localparam int SCREEN_BITS_DEF = 12;

   localparam logic [31:0] PRESS_THRESHOLD = 32'd500;

   localparam int WIDTH_RESET  = 320;
   localparam int HEIGHT_RESET = 240;

   typedef enum logic [2:0] {
      CSR_RAW_X_MIN,
      CSR_RAW_X_MAX,
      CSR_RAW_Y_MIN,
      CSR_RAW_Y_MAX,
      CSR_SCREEN_WIDTH,
      CSR_SCREEN_HEIGHT,
      CSR_ROTATION_MODE,
      CSR_CALIBRATION_VALID
   } csr_index_type;

   typedef enum logic [1:0] {
      ROT_0,
      ROT_90,
      ROT_180,
      ROT_270
   } rot_type;

   typedef struct packed {
      logic pressed;
      logic neg_x;
      logic neg_y;
      logic zero_x;
      logic zero_y;
   } flags_type;

endpackage

@@ rtl/core/tpcr_front.sv @@
// ============================================================================
// tpcr_front
// Threshold test, offsets from the calibration bounds, scaling by the screen
// span and conversion to magnitude and sign, in three stages.
// ============================================================================
module tpcr_front #(
   parameter int RAW_BITS    = tpcr_pkg::RAW_BITS_DEF,
   parameter int SCREEN_BITS = tpcr_pkg::SCREEN_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [RAW_BITS-1:0]             sample_x,
   input  logic [RAW_BITS-1:0]             sample_y,
   input  logic [RAW_BITS-1:0]             sample_pressure,
   input  logic [RAW_BITS-1:0]             raw_x_min,
   input  logic [RAW_BITS-1:0]             raw_x_max,
   input  logic [RAW_BITS-1:0]             raw_y_min,
   input  logic [RAW_BITS-1:0]             raw_y_max,
   input  logic [SCREEN_BITS-1:0]          w_last,
   input  logic [SCREEN_BITS-1:0]          h_last,
   output logic                            out_valid,
   input  logic                            out_ready,
   output tpcr_pkg::flags_type             out_flags,
   output logic [RAW_BITS-1:0]             out_pass_x,
   output logic [RAW_BITS-1:0]             out_pass_y,
   output logic [RAW_BITS+SCREEN_BITS-1:0] out_num_x,
   output logic [RAW_BITS+SCREEN_BITS-1:0] out_num_y,
   output logic [RAW_BITS-1:0]             out_den_x,
   output logic [RAW_BITS-1:0]             out_den_y
);

   localparam int NW = RAW_BITS + SCREEN_BITS;
   localparam int PW = NW + 2;

   logic en_a, en_b, en_c;

   logic                       a_v_ff;
   tpcr_pkg::flags_type        a_flags_ff, a_flags_in;
   logic [RAW_BITS-1:0]        a_pass_x_ff, a_pass_x_in, a_pass_y_ff, a_pass_y_in;
   logic signed [RAW_BITS:0]   a_dx_ff, a_dx_in, a_dy_ff, a_dy_in;
   logic signed [RAW_BITS:0]   a_den_x_ff, a_den_x_in, a_den_y_ff, a_den_y_in;

   logic                       b_v_ff;
   tpcr_pkg::flags_type        b_flags_ff;
   logic [RAW_BITS-1:0]        b_pass_x_ff, b_pass_y_ff;
   logic signed [PW-1:0]       b_prod_x_ff, b_prod_x_in, b_prod_y_ff, b_prod_y_in;
   logic signed [RAW_BITS:0]   b_den_x_ff, b_den_y_ff;

   logic                       c_v_ff;
   tpcr_pkg::flags_type        c_flags_ff, c_flags_in;
   logic [RAW_BITS-1:0]        c_pass_x_ff, c_pass_y_ff;
   logic [NW-1:0]              c_num_x_ff, c_num_x_in, c_num_y_ff, c_num_y_in;
   logic [RAW_BITS-1:0]        c_den_x_ff, c_den_x_in, c_den_y_ff, c_den_y_in;
   logic signed [PW-1:0]       abs_px, abs_py;
   logic signed [RAW_BITS:0]   abs_dx, abs_dy;

   assign en_c     = !c_v_ff || out_ready;
   assign en_b     = !b_v_ff || en_c;
   assign en_a     = !a_v_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      a_flags_in         = '0;
      a_flags_in.pressed = {{(32-RAW_BITS){1'b0}}, sample_pressure} >= tpcr_pkg::PRESS_THRESHOLD;
      a_pass_x_in        = a_flags_in.pressed ? sample_x : '0;
      a_pass_y_in        = a_flags_in.pressed ? sample_y : '0;
      a_dx_in            = $signed({1'b0, sample_x}) - $signed({1'b0, raw_x_max});
      a_dy_in            = $signed({1'b0, sample_y}) - $signed({1'b0, raw_y_min});
      a_den_x_in         = $signed({1'b0, raw_x_min}) - $signed({1'b0, raw_x_max});
      a_den_y_in         = $signed({1'b0, raw_y_max}) - $signed({1'b0, raw_y_min});
   end

   always_comb begin
      b_prod_x_in = PW'(a_dx_ff) * PW'($signed({1'b0, h_last}));
      b_prod_y_in = PW'(a_dy_ff) * PW'($signed({1'b0, w_last}));
   end

   always_comb begin
      abs_px            = b_prod_x_ff[PW-1] ? -b_prod_x_ff : b_prod_x_ff;
      abs_py            = b_prod_y_ff[PW-1] ? -b_prod_y_ff : b_prod_y_ff;
      abs_dx            = b_den_x_ff[RAW_BITS] ? -b_den_x_ff : b_den_x_ff;
      abs_dy            = b_den_y_ff[RAW_BITS] ? -b_den_y_ff : b_den_y_ff;
      c_num_x_in        = abs_px[NW-1:0];
      c_num_y_in        = abs_py[NW-1:0];
      c_den_x_in        = abs_dx[RAW_BITS-1:0];
      c_den_y_in        = abs_dy[RAW_BITS-1:0];
      c_flags_in        = b_flags_ff;
      c_flags_in.neg_x  = b_prod_x_ff[PW-1] ^ b_den_x_ff[RAW_BITS];
      c_flags_in.neg_y  = b_prod_y_ff[PW-1] ^ b_den_y_ff[RAW_BITS];
      c_flags_in.zero_x = b_den_x_ff == '0;
      c_flags_in.zero_y = b_den_y_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else begin
         if (en_a) begin
            a_v_ff <= in_valid;
         end
         if (en_b) begin
            b_v_ff <= a_v_ff;
         end
         if (en_c) begin
            c_v_ff <= b_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         a_flags_ff  <= a_flags_in;
         a_pass_x_ff <= a_pass_x_in;
         a_pass_y_ff <= a_pass_y_in;
         a_dx_ff     <= a_dx_in;
         a_dy_ff     <= a_dy_in;
         a_den_x_ff  <= a_den_x_in;
         a_den_y_ff  <= a_den_y_in;
      end
      if (en_b) begin
         b_flags_ff  <= a_flags_ff;
         b_pass_x_ff <= a_pass_x_ff;
         b_pass_y_ff <= a_pass_y_ff;
         b_prod_x_ff <= b_prod_x_in;
         b_prod_y_ff <= b_prod_y_in;
         b_den_x_ff  <= a_den_x_ff;
         b_den_y_ff  <= a_den_y_ff;
      end
      if (en_c) begin
         c_flags_ff  <= c_flags_in;
         c_pass_x_ff <= b_pass_x_ff;
         c_pass_y_ff <= b_pass_y_ff;
         c_num_x_ff  <= c_num_x_in;
         c_num_y_ff  <= c_num_y_in;
         c_den_x_ff  <= c_den_x_in;
         c_den_y_ff  <= c_den_y_in;
      end
   end

   assign out_valid  = c_v_ff;
   assign out_flags  = c_flags_ff;
   assign out_pass_x = c_pass_x_ff;
   assign out_pass_y = c_pass_y_ff;
   assign out_num_x  = c_num_x_ff;
   assign out_num_y  = c_num_y_ff;
   assign out_den_x  = c_den_x_ff;
   assign out_den_y  = c_den_y_ff;

endmodule

@@ rtl/core/tpcr_div.sv @@
// ============================================================================
// tpcr_div
// Pipelined restoring divider for both axes, one quotient bit per stage,
// with the rest of the request carried alongside.
// ============================================================================
module tpcr_div #(
   parameter int RAW_BITS    = tpcr_pkg::RAW_BITS_DEF,
   parameter int SCREEN_BITS = tpcr_pkg::SCREEN_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  tpcr_pkg::flags_type             in_flags,
   input  logic [RAW_BITS-1:0]             in_pass_x,
   input  logic [RAW_BITS-1:0]             in_pass_y,
   input  logic [RAW_BITS+SCREEN_BITS-1:0] in_num_x,
   input  logic [RAW_BITS+SCREEN_BITS-1:0] in_num_y,
   input  logic [RAW_BITS-1:0]             in_den_x,
   input  logic [RAW_BITS-1:0]             in_den_y,
   output logic                            out_valid,
   input  logic                            out_ready,
   output tpcr_pkg::flags_type             out_flags,
   output logic [RAW_BITS-1:0]             out_pass_x,
   output logic [RAW_BITS-1:0]             out_pass_y,
   output logic [RAW_BITS+SCREEN_BITS-1:0] out_q_x,
   output logic [RAW_BITS+SCREEN_BITS-1:0] out_q_y
);

   localparam int NW = RAW_BITS + SCREEN_BITS;

   logic                      v_ff      [NW];
   logic                      en        [NW];
   tpcr_pkg::flags_type       flags_ff  [NW];
   logic [RAW_BITS-1:0]       pass_x_ff [NW];
   logic [RAW_BITS-1:0]       pass_y_ff [NW];
   logic [RAW_BITS-1:0]       den_x_ff  [NW];
   logic [RAW_BITS-1:0]       den_y_ff  [NW];
   logic [RAW_BITS-1:0]       rem_x_ff  [NW];
   logic [RAW_BITS-1:0]       rem_y_ff  [NW];
   logic [NW-1:0]             numq_x_ff [NW];
   logic [NW-1:0]             numq_y_ff [NW];
   logic [RAW_BITS+NW-1:0]    step_x_in [NW];
   logic [RAW_BITS+NW-1:0]    step_y_in [NW];

   function automatic logic [RAW_BITS+NW-1:0] div_step(
      input logic [RAW_BITS-1:0] rem,
      input logic [NW-1:0]       numq,
      input logic [RAW_BITS-1:0] den
   );
      logic [RAW_BITS:0] trial;
      logic [RAW_BITS:0] diff;
      logic              ge;
      trial = {rem, numq[NW-1]};
      diff  = trial - {1'b0, den};
      ge    = trial >= {1'b0, den};
      return {(ge ? diff[RAW_BITS-1:0] : trial[RAW_BITS-1:0]), numq[NW-2:0], ge};
   endfunction

   assign en[NW-1] = !v_ff[NW-1] || out_ready;
   assign in_ready = en[0];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      if (k == 0) begin : g_first
         assign step_x_in[k] = div_step('0, in_num_x, in_den_x);
         assign step_y_in[k] = div_step('0, in_num_y, in_den_y);

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= in_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (en[k]) begin
               flags_ff[k]  <= in_flags;
               pass_x_ff[k] <= in_pass_x;
               pass_y_ff[k] <= in_pass_y;
               den_x_ff[k]  <= in_den_x;
               den_y_ff[k]  <= in_den_y;
            end
         end
      end else begin : g_next
         assign step_x_in[k] = div_step(rem_x_ff[k-1], numq_x_ff[k-1], den_x_ff[k-1]);
         assign step_y_in[k] = div_step(rem_y_ff[k-1], numq_y_ff[k-1], den_y_ff[k-1]);

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[k] <= 1'b0;
            end else if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end

         always_ff @(posedge clock) begin
            if (en[k]) begin
               flags_ff[k]  <= flags_ff[k-1];
               pass_x_ff[k] <= pass_x_ff[k-1];
               pass_y_ff[k] <= pass_y_ff[k-1];
               den_x_ff[k]  <= den_x_ff[k-1];
               den_y_ff[k]  <= den_y_ff[k-1];
            end
         end
      end

      if (k < NW - 1) begin : g_ready
         assign en[k] = !v_ff[k] || en[k+1];
      end

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_x_ff[k]  <= step_x_in[k][RAW_BITS+NW-1:NW];
            numq_x_ff[k] <= step_x_in[k][NW-1:0];
            rem_y_ff[k]  <= step_y_in[k][RAW_BITS+NW-1:NW];
            numq_y_ff[k] <= step_y_in[k][NW-1:0];
         end
      end
   end

   assign out_valid  = v_ff[NW-1];
   assign out_flags  = flags_ff[NW-1];
   assign out_pass_x = pass_x_ff[NW-1];
   assign out_pass_y = pass_y_ff[NW-1];
   assign out_q_x    = numq_x_ff[NW-1];
   assign out_q_y    = numq_y_ff[NW-1];

endmodule

@@ rtl/core/tpcr_back.sv @@
// ============================================================================
// tpcr_back
// Applies sign and the equal-bounds case to the quotients, then rotates,
// clamps to the screen and holds the response in the output register.
// ============================================================================
module tpcr_back #(
   parameter int RAW_BITS    = tpcr_pkg::RAW_BITS_DEF,
   parameter int SCREEN_BITS = tpcr_pkg::SCREEN_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  tpcr_pkg::flags_type             in_flags,
   input  logic [RAW_BITS-1:0]             in_pass_x,
   input  logic [RAW_BITS-1:0]             in_pass_y,
   input  logic [RAW_BITS+SCREEN_BITS-1:0] in_q_x,
   input  logic [RAW_BITS+SCREEN_BITS-1:0] in_q_y,
   input  logic [SCREEN_BITS-1:0]          w_last,
   input  logic [SCREEN_BITS-1:0]          h_last,
   input  tpcr_pkg::rot_type               rotation,
   input  logic                            calibration_valid,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic                            touch_pressed,
   output logic [RAW_BITS-1:0]             pass_x,
   output logic [RAW_BITS-1:0]             pass_y,
   output logic [SCREEN_BITS-1:0]          screen_x,
   output logic [SCREEN_BITS-1:0]          screen_y,
   output logic                            screen_valid
);

   localparam int NW = RAW_BITS + SCREEN_BITS;
   localparam int TW = NW + 2;

   logic en_d, en_o;

   logic                    d_v_ff;
   tpcr_pkg::flags_type     d_flags_ff;
   logic [RAW_BITS-1:0]     d_pass_x_ff, d_pass_y_ff;
   logic signed [NW:0]      d_sx_ff, d_sx_in, d_sy_ff, d_sy_in;

   logic                    o_v_ff;
   logic                    o_pressed_ff;
   logic [RAW_BITS-1:0]     o_pass_x_ff, o_pass_y_ff;
   logic [SCREEN_BITS-1:0]  o_screen_x_ff, o_screen_x_in, o_screen_y_ff, o_screen_y_in;
   logic                    o_screen_valid_ff, o_screen_valid_in;

   logic signed [TW-1:0]    wl, hl, sx, sy, tx, ty;

   function automatic logic [SCREEN_BITS-1:0] clamp_to(
      input logic signed [TW-1:0] v,
      input logic signed [TW-1:0] hi
   );
      logic [SCREEN_BITS-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > hi) begin
         r = hi[SCREEN_BITS-1:0];
      end else begin
         r = v[SCREEN_BITS-1:0];
      end
      return r;
   endfunction

   assign en_o     = !o_v_ff || out_ready;
   assign en_d     = !d_v_ff || en_o;
   assign in_ready = en_d;

   always_comb begin
      if (in_flags.zero_y) begin
         d_sx_in = '0;
      end else if (in_flags.neg_y) begin
         d_sx_in = -$signed({1'b0, in_q_y});
      end else begin
         d_sx_in = $signed({1'b0, in_q_y});
      end
      if (in_flags.zero_x) begin
         d_sy_in = '0;
      end else if (in_flags.neg_x) begin
         d_sy_in = -$signed({1'b0, in_q_x});
      end else begin
         d_sy_in = $signed({1'b0, in_q_x});
      end
   end

   always_comb begin
      wl = TW'($signed({1'b0, w_last}));
      hl = TW'($signed({1'b0, h_last}));
      sx = TW'(d_sx_ff);
      sy = TW'(d_sy_ff);
      case (rotation)
         tpcr_pkg::ROT_0: begin
            tx = sx;
            ty = sy;
         end
         tpcr_pkg::ROT_90: begin
            tx = sy;
            ty = hl - sx;
         end
         tpcr_pkg::ROT_180: begin
            tx = wl - sx;
            ty = hl - sy;
         end
         tpcr_pkg::ROT_270: begin
            tx = wl - sy;
            ty = sx;
         end
         default: begin
            tx = sx;
            ty = sy;
         end
      endcase
      o_screen_valid_in = d_flags_ff.pressed && calibration_valid;
      o_screen_x_in     = o_screen_valid_in ? clamp_to(tx, wl) : '0;
      o_screen_y_in     = o_screen_valid_in ? clamp_to(ty, hl) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else begin
         if (en_d) begin
            d_v_ff <= in_valid;
         end
         if (en_o) begin
            o_v_ff <= d_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_d) begin
         d_flags_ff  <= in_flags;
         d_pass_x_ff <= in_pass_x;
         d_pass_y_ff <= in_pass_y;
         d_sx_ff     <= d_sx_in;
         d_sy_ff     <= d_sy_in;
      end
      if (en_o) begin
         o_pressed_ff      <= d_flags_ff.pressed;
         o_pass_x_ff       <= d_pass_x_ff;
         o_pass_y_ff       <= d_pass_y_ff;
         o_screen_x_ff     <= o_screen_x_in;
         o_screen_y_ff     <= o_screen_y_in;
         o_screen_valid_ff <= o_screen_valid_in;
      end
   end

   assign out_valid     = o_v_ff;
   assign touch_pressed = o_pressed_ff;
   assign pass_x        = o_pass_x_ff;
   assign pass_y        = o_pass_y_ff;
   assign screen_x      = o_screen_x_ff;
   assign screen_y      = o_screen_y_ff;
   assign screen_valid  = o_screen_valid_ff;

   a_valid_needs_press: assert property (@(posedge clock) disable iff (reset)
      out_valid && screen_valid |-> touch_pressed)
      else $error("Screen coordinates flagged valid on a released touch.");

   a_release_is_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid && !touch_pressed |-> pass_x == '0 && pass_y == '0 &&
         screen_x == '0 && screen_y == '0 && !screen_valid)
      else $error("Released touch carries nonzero fields.");

   a_on_screen: assert property (@(posedge clock) disable iff (reset)
      out_valid && screen_valid |-> screen_x <= w_last && screen_y <= h_last)
      else $error("Screen coordinate lies outside the display.");

endmodule

@@ rtl/core/touch_point_calibrate_rotate.sv @@
// ============================================================================
// touch_point_calibrate_rotate
// Maps raw resistive touch samples to rotated, clamped screen coordinates.
// ============================================================================
// Each request on req_ carries one raw sample (x, y, pressure). Each request
// produces exactly one response on rsp_, in order. A sample with pressure of
// at least 500 is pressed and its raw coordinates pass through; with
// calibration enabled, raw y is scaled onto the width and raw x, inverted,
// onto the height, then rotated and clamped to the display.
// The pipeline takes one request per cycle unless back-pressure on rsp_ has
// filled every stage. Each request passes through the front stages, the
// divider, which resolves one quotient bit per stage, and the back stages.
// When rsp_tready is low the response holds in the output register and
// stages behind it keep filling up any empty slots; req_tready falls only
// once every stage holds a request.
// Registers are to be written through csr_ only while no request is in flight;
// the block itself does not enforce this. They take effect for the next request.
// Reset empties the pipeline and restores the register defaults: full-range
// bounds, 320 by 240, no rotation and calibration off. csr_ready is always high.
// ============================================================================
module touch_point_calibrate_rotate #(
   parameter int RAW_BITS    = tpcr_pkg::RAW_BITS_DEF,
   parameter int SCREEN_BITS = tpcr_pkg::SCREEN_BITS_DEF,
   parameter int REQ_W       = ((3 * RAW_BITS + 7) / 8) * 8,
   parameter int RSP_W       = ((2 * RAW_BITS + 2 * SCREEN_BITS + 7) / 8) * 8,
   parameter int CSR_W       = (RAW_BITS > SCREEN_BITS + 1) ? RAW_BITS : SCREEN_BITS + 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // sample_x, sample_y, sample_pressure
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // pass_x, pass_y, screen_x, screen_y
   output logic [RSP_W-1:0] rsp_tdata,
   // touch_pressed, screen_valid
   output logic [1:0]       rsp_tuser,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [CSR_W-1:0] csr_data
);

   localparam int NW = RAW_BITS + SCREEN_BITS;

   logic [RAW_BITS-1:0]      raw_x_min_ff, raw_x_max_ff, raw_y_min_ff, raw_y_max_ff;
   logic [SCREEN_BITS:0]     screen_width_ff, screen_height_ff;
   tpcr_pkg::rot_type        rotation_mode_ff;
   logic                     calibration_valid_ff;
   logic [SCREEN_BITS-1:0]   w_last_ff, w_last_in, h_last_ff, h_last_in;

   logic                     f_valid, f_ready;
   tpcr_pkg::flags_type      f_flags;
   logic [RAW_BITS-1:0]      f_pass_x, f_pass_y, f_den_x, f_den_y;
   logic [NW-1:0]            f_num_x, f_num_y;

   logic                     q_valid, q_ready;
   tpcr_pkg::flags_type      q_flags;
   logic [RAW_BITS-1:0]      q_pass_x, q_pass_y;
   logic [NW-1:0]            q_x, q_y;

   logic                     touch_pressed, screen_valid;
   logic [RAW_BITS-1:0]      pass_x, pass_y;
   logic [SCREEN_BITS-1:0]   screen_x, screen_y;

   function automatic logic [SCREEN_BITS-1:0] size_last(input logic [SCREEN_BITS:0] s);
      logic [SCREEN_BITS:0]   lim;
      logic [SCREEN_BITS:0]   dec;
      logic [SCREEN_BITS-1:0] r;
      lim = {1'b1, {SCREEN_BITS{1'b0}}};
      dec = s - 1'b1;
      if (s == '0) begin
         r = '0;
      end else if (s > lim) begin
         r = '1;
      end else begin
         r = dec[SCREEN_BITS-1:0];
      end
      return r;
   endfunction

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_x_min_ff         <= '0;
         raw_x_max_ff         <= '1;
         raw_y_min_ff         <= '0;
         raw_y_max_ff         <= '1;
         screen_width_ff      <= (SCREEN_BITS + 1)'(tpcr_pkg::WIDTH_RESET);
         screen_height_ff     <= (SCREEN_BITS + 1)'(tpcr_pkg::HEIGHT_RESET);
         rotation_mode_ff     <= tpcr_pkg::ROT_0;
         calibration_valid_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (tpcr_pkg::csr_index_type'(csr_index))
            tpcr_pkg::CSR_RAW_X_MIN:         raw_x_min_ff <= csr_data[RAW_BITS-1:0];
            tpcr_pkg::CSR_RAW_X_MAX:         raw_x_max_ff <= csr_data[RAW_BITS-1:0];
            tpcr_pkg::CSR_RAW_Y_MIN:         raw_y_min_ff <= csr_data[RAW_BITS-1:0];
            tpcr_pkg::CSR_RAW_Y_MAX:         raw_y_max_ff <= csr_data[RAW_BITS-1:0];
            tpcr_pkg::CSR_SCREEN_WIDTH:      screen_width_ff <= csr_data[SCREEN_BITS:0];
            tpcr_pkg::CSR_SCREEN_HEIGHT:     screen_height_ff <= csr_data[SCREEN_BITS:0];
            tpcr_pkg::CSR_ROTATION_MODE: begin
               rotation_mode_ff <= tpcr_pkg::rot_type'(csr_data[1:0]);
            end
            tpcr_pkg::CSR_CALIBRATION_VALID: calibration_valid_ff <= csr_data[0];
            default: begin
            end
         endcase
      end
   end

   assign w_last_in = size_last(screen_width_ff);
   assign h_last_in = size_last(screen_height_ff);

   always_ff @(posedge clock) begin
      w_last_ff <= w_last_in;
      h_last_ff <= h_last_in;
   end

   tpcr_front #(
      .RAW_BITS    (RAW_BITS),
      .SCREEN_BITS (SCREEN_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .sample_x        (req_tdata[RAW_BITS-1:0]),
      .sample_y        (req_tdata[2*RAW_BITS-1:RAW_BITS]),
      .sample_pressure (req_tdata[3*RAW_BITS-1:2*RAW_BITS]),
      .raw_x_min       (raw_x_min_ff),
      .raw_x_max       (raw_x_max_ff),
      .raw_y_min       (raw_y_min_ff),
      .raw_y_max       (raw_y_max_ff),
      .w_last          (w_last_ff),
      .h_last          (h_last_ff),
      .out_valid       (f_valid),
      .out_ready       (f_ready),
      .out_flags       (f_flags),
      .out_pass_x      (f_pass_x),
      .out_pass_y      (f_pass_y),
      .out_num_x       (f_num_x),
      .out_num_y       (f_num_y),
      .out_den_x       (f_den_x),
      .out_den_y       (f_den_y)
   );

   tpcr_div #(
      .RAW_BITS    (RAW_BITS),
      .SCREEN_BITS (SCREEN_BITS)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (f_valid),
      .in_ready   (f_ready),
      .in_flags   (f_flags),
      .in_pass_x  (f_pass_x),
      .in_pass_y  (f_pass_y),
      .in_num_x   (f_num_x),
      .in_num_y   (f_num_y),
      .in_den_x   (f_den_x),
      .in_den_y   (f_den_y),
      .out_valid  (q_valid),
      .out_ready  (q_ready),
      .out_flags  (q_flags),
      .out_pass_x (q_pass_x),
      .out_pass_y (q_pass_y),
      .out_q_x    (q_x),
      .out_q_y    (q_y)
   );

   tpcr_back #(
      .RAW_BITS    (RAW_BITS),
      .SCREEN_BITS (SCREEN_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (q_valid),
      .in_ready          (q_ready),
      .in_flags          (q_flags),
      .in_pass_x         (q_pass_x),
      .in_pass_y         (q_pass_y),
      .in_q_x            (q_x),
      .in_q_y            (q_y),
      .w_last            (w_last_ff),
      .h_last            (h_last_ff),
      .rotation          (rotation_mode_ff),
      .calibration_valid (calibration_valid_ff),
      .out_valid         (rsp_tvalid),
      .out_ready         (rsp_tready),
      .touch_pressed     (touch_pressed),
      .pass_x            (pass_x),
      .pass_y            (pass_y),
      .screen_x          (screen_x),
      .screen_y          (screen_y),
      .screen_valid      (screen_valid)
   );

   assign rsp_tdata = RSP_W'({screen_y, screen_x, pass_y, pass_x});
   assign rsp_tuser = {screen_valid, touch_pressed};

endmodule
